// File: hw/rtl/lrbs_pkg.sv
package lrbs_pkg;

	localparam int LEN_W = 17;
	localparam logic [LEN_W-1:0] DATA_LENGTH_RST = 17'd65536;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [15:0] address;
		logic [7:0]  byte_value;
	} in_req_t;

	typedef struct packed {
		logic [12:0] longest_length;
		logic [15:0] last_match_offset;
		logic [15:0] match_count;
	} out_resp_t;

endpackage

// File: hw/rtl/largest_repeated_block_search_core.sv
// channel   dir  payload     handshake           note
// in        in   in_req_t    in_valid/in_stall   byte write or search query
// out       out  out_resp_t  out_valid/out_stall one response per query
// cfg       in   17b length  cfg_we              data_length, idle only
//
// A query walks the byte store once per block length n, starting at n = 1:
// each aligned block is visited in ST_BLK, and each byte compared is read in ST_ISS
// and compared in ST_CMP; each length also passes ST_INIT and ST_FIN. One store read pair serves each byte compared.
// Reset clears control and sets data_length to 65536; the store is not cleared.
// in_stall is high while a query runs; a response held by out_stall delays only
// the end of the next query, writes are still taken.
module largest_repeated_block_search_core #(
	parameter int STORE_BYTES = 65536,
	parameter int MAX_BLOCK   = 4096
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  lrbs_pkg::in_req_t      in_payload,
	output logic                   out_valid,
	input  logic                   out_stall,
	output lrbs_pkg::out_resp_t    out_payload,
	input  logic                   cfg_we,
	input  logic [lrbs_pkg::LEN_W-1:0] cfg_data
);
	import lrbs_pkg::*;

	localparam int AW = $clog2(STORE_BYTES);
	localparam int CW = LEN_W + 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_INIT = 3'd1;
	localparam logic [2:0] ST_BLK  = 3'd2;
	localparam logic [2:0] ST_ISS  = 3'd3;
	localparam logic [2:0] ST_CMP  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [7:0] mem [STORE_BYTES];
	logic [7:0] rd_a_q, rd_b_q;

	logic [2:0]       state_q;
	logic [LEN_W-1:0] data_length_q;
	logic [CW-1:0]    q_q, total_q, n_q, off_q, k_q, cnt_q, last_q;
	logic [CW-1:0]    best_len_q, best_off_q, best_cnt_q;
	logic             out_valid_q;
	out_resp_t        out_q;

	logic             in_acc, mem_we, out_load;
	logic [LEN_W-1:0] eff_len;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign mem_we    = in_acc && (in_payload.kind == KIND_WRITE) &&
	                   (32'(in_payload.address) < STORE_BYTES);
	assign eff_len   = (32'(data_length_q) > STORE_BYTES) ? LEN_W'(STORE_BYTES)
	                                                      : data_length_q;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign out_valid   = out_valid_q;
	assign out_payload = out_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[AW'(in_payload.address)] <= in_payload.byte_value;
		end
		if (state_q == ST_ISS) begin
			rd_a_q <= mem[AW'(off_q + k_q)];
			rd_b_q <= mem[AW'(q_q + k_q)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_length_q <= DATA_LENGTH_RST;
		end else if (cfg_we) begin
			data_length_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			q_q        <= '0;
			total_q    <= '0;
			n_q        <= '0;
			off_q      <= '0;
			k_q        <= '0;
			cnt_q      <= '0;
			last_q     <= '0;
			best_len_q <= '0;
			best_off_q <= '0;
			best_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && in_payload.kind == KIND_QUERY) begin
						q_q        <= CW'(in_payload.address);
						total_q    <= CW'(eff_len);
						n_q        <= CW'(1);
						best_len_q <= '0;
						best_off_q <= '0;
						best_cnt_q <= '0;
						state_q    <= ST_INIT;
					end
				end
				ST_INIT: begin
					if (q_q >= total_q || n_q > total_q - q_q || n_q > CW'(MAX_BLOCK)) begin
						state_q <= ST_DONE;
					end else begin
						off_q   <= '0;
						cnt_q   <= '0;
						last_q  <= '0;
						state_q <= ST_BLK;
					end
				end
				ST_BLK: begin
					if (off_q + n_q > total_q) begin
						state_q <= ST_FIN;
					end else if (off_q == q_q) begin
						off_q <= off_q + n_q;
					end else begin
						k_q     <= '0;
						state_q <= ST_ISS;
					end
				end
				ST_ISS: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (rd_a_q != rd_b_q) begin
						off_q   <= off_q + n_q;
						state_q <= ST_BLK;
					end else if (k_q + CW'(1) == n_q) begin
						cnt_q   <= cnt_q + CW'(1);
						last_q  <= off_q;
						off_q   <= off_q + n_q;
						state_q <= ST_BLK;
					end else begin
						k_q     <= k_q + CW'(1);
						state_q <= ST_ISS;
					end
				end
				ST_FIN: begin
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						best_len_q <= n_q;
						best_off_q <= last_q;
						best_cnt_q <= cnt_q;
						n_q        <= n_q + CW'(1);
						state_q    <= ST_INIT;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.longest_length    <= best_len_q[12:0];
			out_q.last_match_offset <= best_off_q[15:0];
			out_q.match_count       <= (best_cnt_q > CW'(16'hFFFF)) ? 16'hFFFF
			                                                       : best_cnt_q[15:0];
		end
	end

	a_rose_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("response raised without a finished search");

	a_len_cnt_agree: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> ((best_len_q == '0) == (best_cnt_q == '0)))
		else $error("best length and count disagree");

	a_byte_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CMP |-> (k_q < n_q && off_q + n_q <= total_q))
		else $error("byte compare outside the block");

endmodule
